[rtl/core/bpm_pkg.sv]
// Shared types, constants and the bracket classifier of the bracket pair matcher.
`timescale 1ns / 1ps
package bpm_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int POS_WIDTH_DEF   = 16;

  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 16;
  localparam int KINDS   = 4;
  localparam int KIND_W  = 2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_RING_SLOTS = 2'd0;
  localparam logic [FIELD_W-1:0]    RING_SLOTS_RST = 16'd16;

  localparam logic [FIELD_W-1:0] PAIR_MAX = 16'hFFFF;

  // Output queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAREN = 2'd0,
    KIND_BRACE = 2'd1,
    KIND_BRACK = 2'd2,
    KIND_ANGLE = 2'd3
  } kind_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    logic [FIELD_W-1:0] closing_pos;
    logic [FIELD_W-1:0] ring_slot;
    logic [FIELD_W-1:0] pair_count;
    logic               overflow;
  } pair_meta_t;

  typedef struct packed {
    logic [FIELD_W-1:0] opening_pos;
    pair_meta_t         meta;
  } pair_word_t;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t r;
    r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    case (c)
      CH_LPAREN: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_LBRACE: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
      CH_LBRACK: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACK};
      CH_LANGLE: r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_RPAREN: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_RBRACE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
      CH_RBRACK: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACK};
      CH_RANGLE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:   r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return r;
  endfunction

endpackage

[rtl/core/bpm_in_if.sv]
// Character channel interface of the bracket pair matcher.
`timescale 1ns / 1ps
interface bpm_in_if
  import bpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/core/bpm_out_if.sv]
// Pair result channel interface of the bracket pair matcher.
`timescale 1ns / 1ps
interface bpm_out_if
  import bpm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] opening_pos;
  logic [FIELD_W-1:0] closing_pos;
  logic [FIELD_W-1:0] ring_slot;
  logic [FIELD_W-1:0] pair_count;
  logic               overflow;

  modport source (output valid, output opening_pos, output closing_pos, output ring_slot,
                  output pair_count, output overflow, input ready);
  modport sink   (input valid, input opening_pos, input closing_pos, input ring_slot,
                  input pair_count, input overflow, output ready);
endinterface

[rtl/core/bpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/bracket_pair_matcher_unit.sv]
// Top level of the bracket pair matcher: per-kind stacks in RAM, pair output queue.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+-------------------------------------------------
//   in_ch   | in  | valid/ready        | char_code[7:0], last_char
//   out_ch  | out | valid/ready        | opening_pos, closing_pos, ring_slot, pair_count,
//           |     |                    | overflow
//   cfg     | in  | APB psel/penable   | ring_slots[15:0] at byte address 0
//
// One character is taken every cycle while in_ch.ready is high; the stack RAM takes one
// push or one pop per character.
// A pair word passes the RAM read and then the output queue register after its closing
// bracket, and may wait in the queue while out_ch is stalled.
// rst_n (synchronous) clears stack fill levels, counters and the queue; the stack RAM
// is not cleared, since an entry is only read after the same string pushed it.
// A stalled output fills a three-word queue; in_ch.ready drops only once the queue plus
// the word in the RAM read stage could not take another pair.
`timescale 1ns / 1ps
module bracket_pair_matcher_unit
  import bpm_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bpm_in_if.sink                in_ch,
  bpm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int DW        = $clog2(STACK_DEPTH + 1);
  localparam int RAM_DEPTH = KINDS * (2 ** AW);
  localparam int RAM_AW    = KIND_W + AW;
  localparam logic [DW-1:0]        DEPTH_FULL = DW'(STACK_DEPTH);
  localparam logic [POS_WIDTH-1:0] POS_MAX    = {POS_WIDTH{1'b1}};

  // ---------------------------------------------------------------- configuration
  logic [FIELD_W-1:0] ring_slots_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr == REG_RING_SLOTS) ? {{(CFG_DATA_W-FIELD_W){1'b0}}, ring_slots_r}
                                            : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_slots_r <= RING_SLOTS_RST;
    end else if (cfg_wr && paddr == REG_RING_SLOTS) begin
      ring_slots_r <= pwdata[FIELD_W-1:0];
    end
  end

  // ---------------------------------------------------------------- string state
  logic [DW-1:0]        depth_r   [KINDS];
  logic [DW-1:0]        depth_nxt [KINDS];
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [FIELD_W-1:0]   pairs_r, pairs_nxt;
  logic [FIELD_W-1:0]   slot_cnt_r, slot_cnt_nxt;
  logic                 ovf_r, ovf_nxt;

  // RAM read stage: the word waits here for its opening position
  logic       s1_v_r, s1_v_nxt;
  pair_meta_t s1_meta_r, s1_meta_nxt;

  // Output queue
  pair_word_t            oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_head_r, oq_tail_r;
  logic [OQ_PTR_W-1:0]   oq_cnt_r;
  logic                  oq_push, oq_pop;

  // Stack RAM port
  logic                 ram_we, ram_re;
  logic [RAM_AW-1:0]    ram_waddr, ram_raddr;
  logic [POS_WIDTH-1:0] ram_rdata;

  logic        acc;
  char_class_t cc;
  logic [DW-1:0]      kdepth;
  logic [DW-1:0]      kdepth_m1;
  logic [FIELD_W-1:0] slots;
  logic [FIELD_W-1:0] slot;
  logic [FIELD_W:0]   slot_inc;

  // Room for one more pair: queue entries plus the word in the read stage stay below 3
  assign in_ch.ready = ({1'b0, oq_cnt_r} + {{OQ_PTR_W{1'b0}}, s1_v_r}) < 3'(OQ_DEPTH);
  assign acc         = in_ch.valid & in_ch.ready;

  assign cc        = classify(in_ch.char_code);
  assign kdepth    = depth_r[cc.kind];
  assign kdepth_m1 = kdepth - DW'(1);

  // Zero slots act as one; a slot counter left at or above a lowered count restarts at zero
  assign slots    = (ring_slots_r == '0) ? FIELD_W'(1) : ring_slots_r;
  assign slot     = (slot_cnt_r < slots) ? slot_cnt_r : '0;
  assign slot_inc = {1'b0, slot} + (FIELD_W+1)'(1);

  always_comb begin
    depth_nxt    = depth_r;
    pos_nxt      = pos_r;
    pairs_nxt    = pairs_r;
    slot_cnt_nxt = slot_cnt_r;
    ovf_nxt      = ovf_r;
    s1_v_nxt     = 1'b0;
    s1_meta_nxt  = s1_meta_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = {cc.kind, kdepth[AW-1:0]};
    ram_raddr    = {cc.kind, kdepth_m1[AW-1:0]};

    if (acc) begin
      if (in_ch.char_code == CH_NUL) begin
        // NUL ends the string without a result
        for (int k = 0; k < KINDS; k++) begin
          depth_nxt[k] = '0;
        end
        pos_nxt      = '0;
        pairs_nxt    = '0;
        slot_cnt_nxt = '0;
        ovf_nxt      = 1'b0;
      end else begin
        if (cc.is_open) begin
          if (kdepth < DEPTH_FULL) begin
            ram_we              = 1'b1;
            depth_nxt[cc.kind]  = kdepth + DW'(1);
          end else begin
            ovf_nxt = 1'b1;   // drop the push, flag it
          end
        end else if (cc.is_close && kdepth != '0) begin
          // Pop: RAM read now, opening position joins the word next cycle.
          // Push and pop never share an edge, so no forwarding is needed.
          ram_re             = 1'b1;
          depth_nxt[cc.kind] = kdepth_m1;
          slot_cnt_nxt       = (slot_inc >= {1'b0, slots}) ? '0 : slot_inc[FIELD_W-1:0];
          pairs_nxt          = (pairs_r != PAIR_MAX) ? pairs_r + FIELD_W'(1) : pairs_r;
          s1_v_nxt           = 1'b1;
          s1_meta_nxt.closing_pos = FIELD_W'(pos_r);
          s1_meta_nxt.ring_slot   = slot;
          s1_meta_nxt.pair_count  = pairs_nxt;
          s1_meta_nxt.overflow    = ovf_r;
        end

        // Advance position, saturating
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_WIDTH'(1);
        end else begin
          ovf_nxt = 1'b1;
        end

        if (in_ch.last_char) begin
          for (int k = 0; k < KINDS; k++) begin
            depth_nxt[k] = '0;
          end
          pos_nxt      = '0;
          pairs_nxt    = '0;
          slot_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
        end
      end
    end
  end

  bpm_ram #(
    .WIDTH (POS_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pos_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KINDS; k++) begin
        depth_r[k] <= '0;
      end
      pos_r      <= '0;
      pairs_r    <= '0;
      slot_cnt_r <= '0;
      ovf_r      <= 1'b0;
      s1_v_r     <= 1'b0;
    end else begin
      depth_r    <= depth_nxt;
      pos_r      <= pos_nxt;
      pairs_r    <= pairs_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      ovf_r      <= ovf_nxt;
      s1_v_r     <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r <= s1_meta_nxt;
  end

  // ---------------------------------------------------------------- output queue
  assign oq_push = s1_v_r;
  assign oq_pop  = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_head_r <= '0;
      oq_tail_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (oq_push) begin
        oq_tail_r <= (oq_tail_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_tail_r + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_head_r <= (oq_head_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_head_r + OQ_PTR_W'(1);
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + OQ_PTR_W'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - OQ_PTR_W'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_tail_r] <= '{opening_pos: FIELD_W'(ram_rdata), meta: s1_meta_r};
    end
  end

  assign out_ch.valid       = (oq_cnt_r != '0);
  assign out_ch.opening_pos = oq_r[oq_head_r].opening_pos;
  assign out_ch.closing_pos = oq_r[oq_head_r].meta.closing_pos;
  assign out_ch.ring_slot   = oq_r[oq_head_r].meta.ring_slot;
  assign out_ch.pair_count  = oq_r[oq_head_r].meta.pair_count;
  assign out_ch.overflow    = oq_r[oq_head_r].meta.overflow;

  // ---------------------------------------------------------------- assertions
  a_oq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, oq_cnt_r} + {{OQ_PTR_W{1'b0}}, s1_v_r}) <= 3'(OQ_DEPTH))
    else $error("output queue overrun");

  a_read_stage_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(acc))
    else $error("pair word without an accepted character");

  a_nul_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.char_code == CH_NUL) |=> (pos_r == '0 && pairs_r == '0))
    else $error("NUL did not end the string");

  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r[0] <= DEPTH_FULL && depth_r[1] <= DEPTH_FULL &&
    depth_r[2] <= DEPTH_FULL && depth_r[3] <= DEPTH_FULL)
    else $error("stack fill level beyond stack depth");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bracket pair matcher: table-driven and random strings.
module testbench;
  import bpm_pkg::*;

  localparam int          CLK_HALF_NS  = 5;
  localparam int          RESET_CYCLES = 5;
  localparam int          STACK_LIMIT  = STACK_DEPTH_DEF;
  localparam logic [15:0] POS_LIMIT    = 16'hFFFF;
  localparam int          DRAIN_CYCLES = 8;     // margin after the last owed word
  localparam int          LONG_HOLD    = 300;
  localparam int          PHASE_CHARS  = 100;
  localparam int          TAIL_PAIRS   = 24;
  localparam int          DIR_ROWS     = 23;
  localparam longint      TIMEOUT_NS   = 64'd2_000_000;

  // How a table row is checked: no word, a word typed in the table, or the predictor.
  typedef enum logic [1:0] {ROW_QUIET, ROW_TYPED, ROW_PREDICTED} row_check_t;
  typedef enum logic [1:0] {STR_CLEAN, STR_BROKEN, STR_DEEP} str_style_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    row_check_t        check;
    pair_word_t        pair;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bpm_in_if  in_ch ();
  bpm_out_if out_ch ();

  bracket_pair_matcher_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Predictor state: one stack of opening positions per bracket kind, plus string counters.
  logic [15:0] open_pos_stack [KINDS][STACK_LIMIT];
  int unsigned stack_fill [KINDS];
  logic [15:0] char_pos;
  logic [15:0] pairs_in_string;
  logic [15:0] next_slot;
  logic [15:0] ring_slots_cfg;
  logic        string_overflow;

  // Pair words still owed by the block, oldest first.
  pair_word_t  pairs_due [$];
  pair_word_t  want_pair;

  stim_row_t   dir_rows [DIR_ROWS];

  // Stimulus controls shared with the result-side process.
  bit          in_gaps_on;
  bit          out_gaps_on;
  bit          hold_req;
  int          gap_pct;

  int unsigned chars_sent;
  int unsigned pairs_checked;
  int unsigned overflow_pairs;
  int unsigned saturated_pairs;
  int unsigned settings_used;
  int unsigned mismatches;

  task automatic clear_string();
    for (int i = 0; i < KINDS; i++) begin
      stack_fill[i] = 0;
    end
    char_pos        = '0;
    pairs_in_string = '0;
    next_slot       = '0;
    string_overflow = 1'b0;
  endtask

  // Advance the predictor by one character; report the pair word it closes, if any.
  task automatic match_bracket(input logic [CHAR_W-1:0] c, input logic last,
                               output logic found, output pair_word_t pw);
    logic        is_open;
    logic        is_close;
    kind_t       k;
    int unsigned slots;
    int unsigned slot;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_PAREN;
    found    = 1'b0;
    pw       = '0;
    case (c)
      CH_LPAREN: begin is_open  = 1'b1; k = KIND_PAREN; end
      CH_LBRACE: begin is_open  = 1'b1; k = KIND_BRACE; end
      CH_LBRACK: begin is_open  = 1'b1; k = KIND_BRACK; end
      CH_LANGLE: begin is_open  = 1'b1; k = KIND_ANGLE; end
      CH_RPAREN: begin is_close = 1'b1; k = KIND_PAREN; end
      CH_RBRACE: begin is_close = 1'b1; k = KIND_BRACE; end
      CH_RBRACK: begin is_close = 1'b1; k = KIND_BRACK; end
      CH_RANGLE: begin is_close = 1'b1; k = KIND_ANGLE; end
      default: begin end
    endcase
    // A NUL byte ends the string on the spot and closes nothing.
    if (c == CH_NUL) begin
      clear_string();
      return;
    end
    if (is_open) begin
      // Drop an opening bracket that finds its stack full and flag the string.
      if (stack_fill[k] < STACK_LIMIT) begin
        open_pos_stack[k][stack_fill[k]] = char_pos;
        stack_fill[k]++;
      end else begin
        string_overflow = 1'b1;
      end
    end else if (is_close && stack_fill[k] > 0) begin
      // Zero slots act as one; a counter left at or above a lowered setting restarts at 0.
      slots = (ring_slots_cfg == 0) ? 1 : ring_slots_cfg;
      slot  = (next_slot < slots) ? next_slot : 0;
      stack_fill[k]--;
      next_slot = (slot + 1 >= slots) ? 16'd0 : 16'(slot + 1);
      if (pairs_in_string != PAIR_MAX) begin
        pairs_in_string++;
      end
      pw.opening_pos      = open_pos_stack[k][stack_fill[k]];
      pw.meta.closing_pos = char_pos;
      pw.meta.ring_slot   = 16'(slot);
      pw.meta.pair_count  = pairs_in_string;
      pw.meta.overflow    = string_overflow;
      found               = 1'b1;
    end
    // Hold the position at its ceiling once reached; every later byte shares it.
    if (char_pos != POS_LIMIT) begin
      char_pos++;
    end else begin
      string_overflow = 1'b1;
    end
    if (last) begin
      clear_string();
    end
  endtask

  // Offer one character, wait for the handshake, then book the word it owes.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last,
                           input row_check_t check = ROW_PREDICTED,
                           input pair_word_t typed = '0);
    logic       found;
    pair_word_t pw;
    if (in_gaps_on && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    match_bracket(c, last, found, pw);
    if (check == ROW_TYPED) begin
      pairs_due.push_back(typed);
    end else if (check == ROW_PREDICTED && found) begin
      pairs_due.push_back(pw);
    end
  endtask

  // Stop offering, wait out every owed word and the pipeline behind the last one.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_ring_slots(input logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_RING_SLOTS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== want) begin
      $display("%0t ns: ring_slots read back expected %0d actual %0d", $time, want,
               prdata[15:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write ring_slots with random upper bits, which the register ignores, then read it back.
  task automatic write_ring_slots(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RING_SLOTS;
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ring_slots_cfg = value;
    settings_used++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_ring_slots(value);
  endtask

  // Build one string: nested brackets with filler, optionally broken or nested past the stack.
  task automatic build_string(input str_style_t style, input int len,
                              output logic [CHAR_W-1:0] s [$]);
    logic [CHAR_W-1:0] open_ch  [KINDS] = '{CH_LPAREN, CH_LBRACE, CH_LBRACK, CH_LANGLE};
    logic [CHAR_W-1:0] close_ch [KINDS] = '{CH_RPAREN, CH_RBRACE, CH_RBRACK, CH_RANGLE};
    int                kinds_open [$];
    int                r;
    int                k;
    int                nest_cap;
    s = {};
    nest_cap = (style == STR_DEEP) ? STACK_LIMIT + 16 : 12;
    if (style == STR_DEEP) begin
      k = $urandom_range(0, KINDS - 1);
      repeat ($urandom_range(STACK_LIMIT - 2, STACK_LIMIT + 8)) begin
        s.push_back(open_ch[k]);
        kinds_open.push_back(k);
      end
    end
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (style == STR_BROKEN && r < 8) begin
        s.push_back(close_ch[$urandom_range(0, KINDS - 1)]);
      end else if (style == STR_BROKEN && r < 16) begin
        s.push_back(8'($urandom_range(0, 255)));
      end else if (r < 40 && kinds_open.size() < nest_cap) begin
        k = $urandom_range(0, KINDS - 1);
        s.push_back(open_ch[k]);
        kinds_open.push_back(k);
      end else if (r < 75 && kinds_open.size() > 0) begin
        s.push_back(close_ch[kinds_open.pop_back()]);
      end else begin
        s.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
    end
    // Broken strings may leave brackets open or end on a NUL.
    if (style != STR_BROKEN || $urandom_range(0, 1) == 0) begin
      while (kinds_open.size() > 0) s.push_back(close_ch[kinds_open.pop_back()]);
    end
    if (style == STR_BROKEN && $urandom_range(0, 3) == 0) begin
      s.push_back(CH_NUL);
    end
  endtask

  task automatic send_string(input logic [CHAR_W-1:0] s [$], input bit mark_last);
    // Some strings run without gaps at all.
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
    foreach (s[i]) begin
      send_char(s[i], mark_last && (i == s.size() - 1));
    end
  endtask

  task automatic run_strings(input int budget);
    int unsigned       start;
    int                r;
    str_style_t        style;
    logic [CHAR_W-1:0] s [$];
    start = chars_sent;
    while (chars_sent - start < budget) begin
      r     = $urandom_range(0, 99);
      style = (r < 8) ? STR_DEEP : (r < 35) ? STR_BROKEN : STR_CLEAN;
      build_string(style, $urandom_range(4, 40), s);
      // Let a few strings run on into the next one.
      send_string(s, $urandom_range(0, 9) != 0);
    end
  endtask

  function automatic stim_row_t stim(input logic [CHAR_W-1:0] c, input logic last,
                                     input row_check_t check, input int op = 0,
                                     input int cl = 0, input int sl = 0, input int cnt = 0);
    stim_row_t r;
    r                     = '0;
    r.char_code           = c;
    r.last_char           = last;
    r.check               = check;
    r.pair.opening_pos    = 16'(op);
    r.pair.meta.closing_pos = 16'(cl);
    r.pair.meta.ring_slot   = 16'(sl);
    r.pair.meta.pair_count  = 16'(cnt);
    r.pair.meta.overflow    = 1'b0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every word taken from the block with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pairs_due.size() == 0) begin
        $display("%0t ns: pair word with none expected, actual open %0d close %0d", $time,
                 out_ch.opening_pos, out_ch.closing_pos);
        mismatches++;
      end else begin
        want_pair = pairs_due.pop_front();
        check_field("opening_pos", want_pair.opening_pos, out_ch.opening_pos);
        check_field("closing_pos", want_pair.meta.closing_pos, out_ch.closing_pos);
        check_field("ring_slot", want_pair.meta.ring_slot, out_ch.ring_slot);
        check_field("pair_count", want_pair.meta.pair_count, out_ch.pair_count);
        check_field("overflow", 16'(want_pair.meta.overflow), 16'(out_ch.overflow));
        pairs_checked++;
        if (out_ch.overflow) begin
          overflow_pairs++;
        end
        if (out_ch.pair_count == PAIR_MAX) begin
          saturated_pairs++;
        end
      end
    end
  end

  // Drive out_ch.ready: random stall bursts, a long hold on request, steady when idling is off.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (out_gaps_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat (out_gaps_on ? $urandom_range(1, 30) : 1) @(posedge clk);
      end
    end
  end

  // Guard against a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d pair words still owed", pairs_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CHAR_W-1:0] s [$];
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    in_gaps_on      = 1'b1;
    out_gaps_on     = 1'b1;
    hold_req        = 1'b0;
    gap_pct         = 25;
    ring_slots_cfg  = RING_SLOTS_RST;
    clear_string();

    // Directed table at the reset setting of 16 slots. Positions restart after each string end.
    dir_rows = '{
      stim(CH_LPAREN, 1'b0, ROW_QUIET),
      stim(CH_RPAREN, 1'b0, ROW_TYPED, 0, 1, 0, 1),
      stim(CH_RPAREN, 1'b0, ROW_QUIET),                // empty stack: ignored
      stim(CH_LBRACE, 1'b0, ROW_QUIET),
      stim(CH_LBRACK, 1'b0, ROW_QUIET),
      stim(CH_LANGLE, 1'b0, ROW_QUIET),
      stim(CH_RANGLE, 1'b0, ROW_TYPED, 5, 6, 1, 2),
      stim(CH_RBRACK, 1'b0, ROW_TYPED, 4, 7, 2, 3),
      stim(CH_RBRACE, 1'b0, ROW_TYPED, 3, 8, 3, 4),
      stim(8'hFF,     1'b0, ROW_PREDICTED),
      stim(CH_NUL,    1'b0, ROW_QUIET),                // NUL ends the string
      stim(CH_LPAREN, 1'b0, ROW_QUIET),
      stim(CH_LPAREN, 1'b0, ROW_QUIET),
      stim(CH_RBRACE, 1'b0, ROW_QUIET),                // other kind, nothing to close
      stim(CH_RPAREN, 1'b0, ROW_TYPED, 1, 3, 0, 1),
      stim(CH_RPAREN, 1'b1, ROW_TYPED, 0, 4, 1, 2),
      stim(8'h41,     1'b0, ROW_QUIET),
      stim(CH_LANGLE, 1'b0, ROW_QUIET),
      stim(CH_NUL,    1'b1, ROW_QUIET),                // NUL carrying the last flag
      stim(CH_RANGLE, 1'b0, ROW_QUIET),                // the open angle went with the string
      stim(CH_LBRACK, 1'b0, ROW_PREDICTED),
      stim(CH_RBRACK, 1'b1, ROW_TYPED, 1, 2, 0, 1),
      stim(8'h80,     1'b1, ROW_PREDICTED)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_ring_slots(RING_SLOTS_RST);

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].char_code, dir_rows[i].last_char, dir_rows[i].check,
                dir_rows[i].pair);
    end
    drain_results();

    // Random strings at the extremes of ring_slots and at zero.
    write_ring_slots(16'd1);
    run_strings(PHASE_CHARS);
    drain_results();
    write_ring_slots(16'hFFFF);
    out_gaps_on = 1'b0;
    run_strings(PHASE_CHARS);
    drain_results();
    out_gaps_on = 1'b1;
    write_ring_slots(16'd0);
    run_strings(PHASE_CHARS);
    drain_results();

    // Lower ring_slots while a string is open: the slot counter sits above the new count.
    write_ring_slots(16'd16);
    repeat (10) begin
      send_char(CH_LPAREN, 1'b0);
      send_char(CH_RPAREN, 1'b0);
    end
    drain_results();
    write_ring_slots(16'd4);
    build_string(STR_CLEAN, 24, s);
    send_string(s, 1'b1);
    drain_results();

    // Hold the result side for a long stretch while characters keep coming, so the
    // queue fills and the input stalls; then pause the sender until all words are out.
    write_ring_slots(16'($urandom_range(2, 40)));
    hold_req   = 1'b1;
    in_gaps_on = 1'b0;
    repeat (48) begin
      send_char(CH_LBRACK, 1'b0);
      send_char(CH_RBRACK, 1'b0);
    end
    send_char(8'h2E, 1'b1);
    in_gaps_on = 1'b1;
    drain_results();

    write_ring_slots(16'($urandom_range(2, 16'hFFFE)));
    run_strings(PHASE_CHARS);
    drain_results();
    write_ring_slots(16'($urandom_range(2, 12)));
    run_strings(PHASE_CHARS);
    drain_results();

    // Last part, no idling: back-to-back pairs with an angle bracket held open across
    // all of them and a few nested closes at the end.
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    write_ring_slots(16'hFFFF);
    send_char(CH_LANGLE, 1'b0);
    repeat (TAIL_PAIRS) begin
      send_char(CH_LPAREN, 1'b0);
      send_char(CH_RPAREN, 1'b0);
    end
    send_char(CH_LBRACE, 1'b0);
    send_char(CH_LBRACK, 1'b0);
    send_char(8'h7A, 1'b0);
    send_char(CH_RBRACK, 1'b0);
    send_char(CH_RBRACE, 1'b0);
    send_char(CH_RANGLE, 1'b1);
    build_string(STR_CLEAN, 20, s);
    send_string(s, 1'b1);
    drain_results();

    $display("run covered %0d characters and %0d checked pair words over %0d ring_slots values",
             chars_sent, pairs_checked, settings_used);
    $display("%0d words carried the overflow flag, %0d a saturated pair count",
             overflow_pairs, saturated_pairs);
    if (mismatches == 0 && pairs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bpm_pkg.sv
rtl/core/bpm_in_if.sv
rtl/core/bpm_out_if.sv
rtl/core/bpm_ram.sv
rtl/core/bracket_pair_matcher_unit.sv
dv/testbench.sv
